>>> hdl/assert_macros.svh
// Concurrent assertion helpers for the page bitmap allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed in %m");

// Flag cond if it is ever true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition in %m");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

>>> hdl/pba_pkg.sv
package pba_pkg;

  localparam int MAX_PAGES_DEF     = 32768;
  localparam int MAP_WORD_BITS_DEF = 64;

  localparam logic [15:0] MANAGED_RESET = 16'd32768;
  localparam logic [15:0] COUNT_SAT     = 16'hFFFF;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_FILL  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [14:0] page_number;
  } pba_req_t;

  typedef struct packed {
    logic [14:0] result_page;
    logic        success;
    logic [15:0] free_count;
  } pba_rsp_t;

endpackage

>>> hdl/pba_ram.sv
module pba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/page_bitmap_allocator_top.sv
// First-fit page allocator over a used/free bitmap held in one RAM.
// Command channel: request is taken at a rising edge with start high and busy
// low. Actions: allocate the lowest free page below the limit, free one page,
// or mark every page used. Each command yields exactly one response, shown on
// response for the single cycle in which done is high; it cannot be stalled.
// Configuration: cfg_data is written to the page limit when cfg_valid and
// cfg_ready are high; cfg_ready is always high, write only while busy is low.
// Scanning: allocate scans one map word per cycle behind a registered RAM
// read; free walks the words up to its page in the same way; mark-all
// sweeps all MAP_WORDS words, one per cycle, then responds. Bad frees and
// unused codes respond straight from idle, without a scan.
// After reset the block runs the same sweep, setting every map word to used,
// with busy high and no response; the free count is zero.
// Only one command is in flight: busy stays high until its response is shown.
`include "assert_macros.svh"

module page_bitmap_allocator_top
  import pba_pkg::*;
#(
  parameter int MAX_PAGES     = MAX_PAGES_DEF,
  parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  pba_req_t    request,
  output logic        done,
  output pba_rsp_t    response,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(MAP_WORD_BITS);
  localparam int BASE_RAW  = $clog2(MAX_PAGES + MAP_WORD_BITS) + 1;
  localparam int BASE_W    = (BASE_RAW > 17) ? BASE_RAW : 17;
  localparam int CNT_W     = $clog2(MAX_PAGES + 1);

  typedef enum logic [1:0] {
    ST_FILL,
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t                   state;
  logic [15:0]              managed_pages;
  logic [CNT_W-1:0]         free_cnt;
  logic [WORD_W-1:0]        fill_word;
  logic                     fill_report;
  logic [1:0]               act;
  logic [14:0]              page;
  logic [WORD_W-1:0]        word;
  logic [BASE_W-1:0]        base;
  logic                     chk_valid;
  logic [WORD_W-1:0]        chk_word;
  logic [BASE_W-1:0]        chk_base;

  logic [15:0]              lim;
  logic [BASE_W-1:0]        lim_ext;
  logic [BASE_W-1:0]        rem;
  logic [BASE_W-1:0]        off;
  logic [BASE_W-1:0]        alloc_page;
  logic [MAP_WORD_BITS-1:0] rdata;
  logic [MAP_WORD_BITS-1:0] lim_mask;
  logic [MAP_WORD_BITS-1:0] avail;
  logic [MAP_WORD_BITS-1:0] low_hot;
  logic [MAP_WORD_BITS-1:0] free_hot;
  logic [MAP_WORD_BITS-1:0] wdata;
  logic [BIT_W-1:0]         alloc_idx;
  logic [BIT_W-1:0]         free_bit;
  logic                     found_alloc;
  logic                     free_hit;
  logic                     bit_used;
  logic                     issue_ok;
  logic                     is_alloc;
  logic                     ram_we;
  logic                     ram_re;
  logic [WORD_W-1:0]        waddr;
  logic [CNT_W-1:0]         cnt_inc;
  logic [CNT_W-1:0]         cnt_dec;

  function automatic logic [15:0] sat16(input logic [CNT_W-1:0] c);
    logic [CNT_W+16:0] w;
    w = (CNT_W + 17)'(c);
    return (w > (CNT_W + 17)'(COUNT_SAT)) ? COUNT_SAT : w[15:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);

  assign lim     = (32'(managed_pages) > MAX_PAGES) ? 16'(MAX_PAGES) : managed_pages;
  assign lim_ext = BASE_W'(lim);
  assign rem     = lim_ext - chk_base;
  assign off     = BASE_W'(page) - chk_base;
  assign is_alloc = (act == ACT_ALLOC);
  assign issue_ok = (base < lim_ext);

  always_comb begin
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      lim_mask[b] = (BASE_W'(b) < rem);
    end
  end

  assign avail       = ~rdata & lim_mask;
  assign found_alloc = |avail;
  assign low_hot     = avail & (~avail + MAP_WORD_BITS'(1));

  always_comb begin
    alloc_idx = '0;
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      if (low_hot[b]) begin
        alloc_idx = alloc_idx | BIT_W'(b);
      end
    end
  end

  assign alloc_page = chk_base + BASE_W'(alloc_idx);
  assign free_hit   = (off < BASE_W'(MAP_WORD_BITS));
  assign free_bit   = off[BIT_W-1:0];
  assign bit_used   = rdata[free_bit];
  assign free_hot   = MAP_WORD_BITS'(1) << free_bit;
  assign cnt_inc    = free_cnt + CNT_W'(1);
  assign cnt_dec    = (free_cnt != '0) ? free_cnt - CNT_W'(1) : free_cnt;

  always_comb begin
    ram_we = 1'b0;
    waddr  = chk_word;
    wdata  = is_alloc ? (rdata | low_hot) : (rdata & ~free_hot);
    ram_re = (state == ST_SCAN) && issue_ok;
    case (state)
      ST_FILL: begin
        ram_we = 1'b1;
        waddr  = fill_word;
        wdata  = '1;
      end
      ST_SCAN: begin
        ram_we = chk_valid && (is_alloc ? found_alloc : (free_hit && bit_used));
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  pba_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (word),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_FILL;
      managed_pages <= MANAGED_RESET;
      free_cnt      <= '0;
      fill_word     <= '0;
      fill_report   <= 1'b0;
      chk_valid     <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        managed_pages <= cfg_data;
      end
      case (state)
        ST_FILL: begin
          fill_word <= fill_word + WORD_W'(1);
          if (fill_word == WORD_W'(MAP_WORDS - 1)) begin
            state       <= ST_IDLE;
            fill_report <= 1'b0;
            if (fill_report) begin
              done     <= 1'b1;
              response <= '{result_page: page, success: 1'b1, free_count: 16'd0};
            end
          end
        end
        ST_IDLE: begin
          if (start) begin
            act       <= request.action;
            page      <= request.page_number;
            word      <= '0;
            base      <= '0;
            chk_valid <= 1'b0;
            case (request.action)
              ACT_ALLOC: begin
                if (lim == 16'd0) begin
                  done     <= 1'b1;
                  response <= '{result_page: 15'd0, success: 1'b0,
                                free_count: sat16(free_cnt)};
                end else begin
                  state <= ST_SCAN;
                end
              end
              ACT_FREE: begin
                if (BASE_W'(request.page_number) >= lim_ext) begin
                  done     <= 1'b1;
                  response <= '{result_page: request.page_number, success: 1'b0,
                                free_count: sat16(free_cnt)};
                end else begin
                  state <= ST_SCAN;
                end
              end
              ACT_FILL: begin
                free_cnt    <= '0;
                fill_word   <= '0;
                fill_report <= 1'b1;
                state       <= ST_FILL;
              end
              default: begin
                done     <= 1'b1;
                response <= '{result_page: request.page_number, success: 1'b0,
                              free_count: sat16(free_cnt)};
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (chk_valid && is_alloc && found_alloc) begin
            free_cnt <= cnt_dec;
            done     <= 1'b1;
            response <= '{result_page: alloc_page[14:0], success: 1'b1,
                          free_count: sat16(cnt_dec)};
            state    <= ST_IDLE;
          end else if (chk_valid && !is_alloc && free_hit) begin
            if (bit_used) begin
              free_cnt <= cnt_inc;
            end
            done     <= 1'b1;
            response <= '{result_page: page, success: bit_used,
                          free_count: sat16(bit_used ? cnt_inc : free_cnt)};
            state    <= ST_IDLE;
          end else if (!issue_ok) begin
            done     <= 1'b1;
            response <= '{result_page: is_alloc ? 15'd0 : page, success: 1'b0,
                          free_count: sat16(free_cnt)};
            state    <= ST_IDLE;
          end else begin
            chk_valid <= 1'b1;
            chk_word  <= word;
            chk_base  <= base;
            word      <= word + WORD_W'(1);
            base      <= base + BASE_W'(MAP_WORD_BITS);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_done_not_busy, clk, rst, done |-> !busy)
  `ASSERT_NEVER(a_write_while_idle, clk, rst, ram_we && !busy)
  `ASSERT_ALWAYS(a_check_below_limit, clk, rst, (state == ST_SCAN && chk_valid) |-> (chk_base < lim_ext))

endmodule
